[src/scr_pkg.sv]
// scr_pkg: shared types, constants and helpers of the segment coordinate restorer
// no dependencies; used by scr_alu, segment_coordinate_restorer and scr_checker

package scr_pkg;

  // map geometry
  localparam int MAP_DEPTH  = 4096;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam int CNT_W      = MAP_AW + 1;
  localparam int POS_W      = 30;
  localparam int ENT_W      = 2 * POS_W;
  localparam int MAX_PIECES = 64;
  localparam int PIECE_W    = $clog2(MAX_PIECES) + 1;

  localparam logic [POS_W-1:0] CEILING_POS = POS_W'(1000000000);
  localparam logic [POS_W-1:0] LEN_RESET   = POS_W'(999999999);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_B = 1'b1;

  typedef enum logic [1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_FINISH  = 2'd2,
    FUNC_SEGMENT = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_INTERVAL = 3'd1,
    ST_OUT_OF_ORDER = 3'd2,
    ST_MAP_FULL     = 3'd3,
    ST_SEARCH_FAIL  = 3'd4,
    ST_BAD_SEGMENT  = 3'd5,
    ST_TOO_MANY     = 3'd6
  } status_t;

  typedef struct packed {
    func_t             func;
    logic              first_of_alignment;
    logic [POS_W-1:0]  begin_a;
    logic [POS_W-1:0]  begin_b;
    logic [POS_W-1:0]  end_a;
    logic [POS_W-1:0]  end_b;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]  orig_begin_a;
    logic [POS_W-1:0]  orig_begin_b;
    logic [POS_W-1:0]  orig_end_a;
    logic [POS_W-1:0]  orig_end_b;
    logic              group_start;
    logic              last_piece;
    status_t           status;
  } out_t;

  // one map entry: stripped position and cumulative removed length
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  off;
  } ent_t;

  // shared adder control: invert second operand, carry in
  typedef struct packed {
    logic inv;
    logic cin;
  } alu_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_ALU, S_CWR, S_FIN, S_FIN_MAP, S_FIN_FLOOR, S_FIN_CEIL,
    S_FIN_DONE, S_SEG, S_F_RD1, S_F_NX, S_F_RD0, S_F_CK, S_UP_RD, S_UP_CK,
    S_DN_RD, S_DN_CK, S_PIECE, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    STP_CP, STP_CT, STP_CR, STP_DA, STP_DB, STP_LM1, STP_OBA, STP_OBB,
    STP_OEA, STP_OEB, STP_NBA, STP_NBB
  } step_t;

  // result of a load or finish item, or of an error without coordinates
  function automatic out_t status_beat(status_t st);
    out_t o;
    o = '0;
    o.last_piece = 1'b1;
    o.status     = st;
    return o;
  endfunction

endpackage

[src/scr_ram.sv]
// scr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module scr_ram #(
  parameter int W     = 60,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/scr_alu.sv]
// scr_alu: shared 30-bit adder/subtractor used for every map and piece sum
// depends on scr_pkg

module scr_alu (
  input  logic [scr_pkg::POS_W-1:0] x,
  input  logic [scr_pkg::POS_W-1:0] y,
  input  scr_pkg::alu_ctl_t         ctl,
  output logic [scr_pkg::POS_W-1:0] r
);

  // sum modulo 2^30, subtraction as invert plus carry
  assign r = x + (ctl.inv ? ~y : y) + {{(scr_pkg::POS_W-1){1'b0}}, ctl.cin};

endmodule

[src/segment_coordinate_restorer.sv]
// A load checks the interval; committing a pending interval runs the map sums in the adder.
// Finish commits any pending interval and writes the floor and ceiling entry of each map.
// A segment reads the map entries, runs the piece sums in the adder and builds and hands off
// each piece beat; a linear search over both maps precedes each later piece and a new group.
// One item at a time; map and piece sums share the single adder; result stalls hold the beat.
// Reset: synchronous active low, sets counts to one and clears cursors, pending intervals and flags.

module segment_coordinate_restorer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  scr_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output scr_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [scr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scr_pkg::POS_W-1:0]     cfg_data
);

  localparam int PW = scr_pkg::POS_W;
  localparam int AW = scr_pkg::MAP_AW;
  localparam int CW = scr_pkg::CNT_W;
  localparam int NW = scr_pkg::PIECE_W;

  scr_pkg::state_t state_r, state_nxt;
  scr_pkg::step_t  step_r, step_nxt;
  scr_pkg::func_t  func_r, func_nxt;

  logic          sel_r, sel_nxt;
  logic          first_r, first_nxt;
  logic [PW-1:0] ba_r, ba_nxt, bb_r, bb_nxt, ea_r, ea_nxt, eb_r, eb_nxt;
  logic [PW-1:0] len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic          pv_a_r, pv_a_nxt, pv_b_r, pv_b_nxt;
  logic [PW-1:0] pb_a_r, pb_a_nxt, pe_a_r, pe_a_nxt, pb_b_r, pb_b_nxt, pe_b_r, pe_b_nxt;
  logic [PW-1:0] rem_a_r, rem_a_nxt, rem_b_r, rem_b_nxt;
  logic [AW-1:0] cur_a_r, cur_a_nxt, cur_b_r, cur_b_nxt, idx_r, idx_nxt;
  logic          ready_r, ready_nxt, group_r, group_nxt;
  logic [PW-1:0] bfirst_r, bfirst_nxt, blast_r, blast_nxt;
  logic          fail_r, fail_nxt, init_r, init_nxt, fresh_r, fresh_nxt;
  logic          final_r, final_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [PW-1:0] na_r, na_nxt, nb_r, nb_nxt, oa_r, oa_nxt, ob_r, ob_nxt;
  logic [PW-1:0] da_r, da_nxt, db_r, db_nxt, lm1_r, lm1_nxt;
  logic [PW-1:0] oba_r, oba_nxt, obb_r, obb_nxt, oea_r, oea_nxt, oeb_r, oeb_nxt;
  logic [PW-1:0] cp_r, cp_nxt, ct_r, ct_nxt;
  scr_pkg::out_t em_r, em_nxt, out_data_r, out_data_nxt;
  logic          out_valid_r, out_valid_nxt;

  // map rams
  logic          we_a, we_b;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  scr_pkg::ent_t wdata, rd_a, rd_b;

  scr_ram #(.W(scr_pkg::ENT_W), .DEPTH(scr_pkg::MAP_DEPTH)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr_a), .rdata(rd_a)
  );

  scr_ram #(.W(scr_pkg::ENT_W), .DEPTH(scr_pkg::MAP_DEPTH)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr_b), .rdata(rd_b)
  );

  // shared adder
  logic [PW-1:0]     alu_x, alu_y, alu_r;
  scr_pkg::alu_ctl_t alu_ctl;

  scr_alu u_alu (.x(alu_x), .y(alu_y), .ctl(alu_ctl), .r(alu_r));

  // selected map view
  logic [CW-1:0] cnt_s;
  logic          pv_s;
  logic [PW-1:0] pb_s, pe_s, rem_s, len_s, b_s;
  scr_pkg::ent_t rd_s;

  assign cnt_s = sel_r ? cnt_b_r : cnt_a_r;
  assign pv_s  = sel_r ? pv_b_r  : pv_a_r;
  assign pb_s  = sel_r ? pb_b_r  : pb_a_r;
  assign pe_s  = sel_r ? pe_b_r  : pe_a_r;
  assign rem_s = sel_r ? rem_b_r : rem_a_r;
  assign len_s = sel_r ? len_b_r : len_a_r;
  assign b_s   = sel_r ? bb_r    : ba_r;
  assign rd_s  = sel_r ? rd_b    : rd_a;

  // load decisions
  logic ld_bad, ld_new, ld_full;
  assign ld_bad  = (ba_r > ea_r) || (ea_r > len_s);
  assign ld_new  = !pv_s || ({1'b0, ba_r} > ({1'b0, pe_s} + 31'd1));
  assign ld_full = (cnt_s + CW'(pv_s)) >= CW'(scr_pkg::MAP_DEPTH - 1);

  // cursor clamps at segment start
  logic [CW-1:0] lim_a, lim_b;
  assign lim_a = cnt_a_r - CW'(2);
  assign lim_b = cnt_b_r - CW'(2);

  // search step outcome
  logic [CW-1:0] nidx;
  logic          up_le, dn_gt, srch_fail, srch_done, fail_now;
  assign nidx  = {1'b0, idx_r} + CW'(1);
  assign up_le = rd_s.pos <= b_s;
  assign dn_gt = rd_s.pos > b_s;
  always_comb begin
    srch_fail = 1'b0;
    srch_done = 1'b0;
    if (state_r == scr_pkg::S_UP_CK) begin
      srch_fail = up_le && (nidx >= cnt_s - CW'(1));
      srch_done = srch_fail;
    end else if (state_r == scr_pkg::S_DN_CK) begin
      srch_fail = dn_gt && (idx_r == '0);
      srch_done = !dn_gt || srch_fail;
    end
  end
  assign fail_now = fail_r || srch_fail;

  // segment checks
  logic init_fresh, seg_bad, seg_fin, piece_over, piece_max, out_free;
  assign init_fresh = first_r || !group_r || (ba_r >= rd_a.pos) || (bb_r >= rd_b.pos);
  assign seg_bad    = (rd_a.pos > ba_r) || (na_r <= ba_r) ||
                      (rd_b.pos > bb_r) || (nb_r <= bb_r);
  assign seg_fin    = (ea_r < na_r) && (eb_r < nb_r);
  assign piece_over = (ba_r > ea_r) || (bb_r > eb_r);
  assign piece_max  = (n_r + NW'(1)) >= NW'(scr_pkg::MAX_PIECES);
  assign out_free   = !out_valid_r || !out_stall;

  logic [PW-1:0] len_m;
  assign len_m = (da_r < db_r) ? da_r : db_r;

  logic fin_bad;
  assign fin_bad = (cnt_b_r >= CW'(3)) &&
                   ((bfirst_r == '0) || (blast_r >= scr_pkg::CEILING_POS));

  // shared adder operand selection
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_ctl = '{inv: 1'b0, cin: 1'b0};
    unique case (step_r)
      scr_pkg::STP_CP:  begin alu_x = pb_s;  alu_y = rem_s; alu_ctl = '{1'b1, 1'b1}; end
      scr_pkg::STP_CT:  begin alu_x = pe_s;  alu_y = pb_s;  alu_ctl = '{1'b1, 1'b1}; end
      scr_pkg::STP_CR:  begin alu_x = rem_s; alu_y = ct_r;  alu_ctl = '{1'b0, 1'b1}; end
      scr_pkg::STP_DA:  begin alu_x = na_r;  alu_y = ba_r;  alu_ctl = '{1'b1, 1'b1}; end
      scr_pkg::STP_DB:  begin alu_x = nb_r;  alu_y = bb_r;  alu_ctl = '{1'b1, 1'b1}; end
      scr_pkg::STP_LM1: begin alu_x = len_m; alu_y = PW'(1); alu_ctl = '{1'b1, 1'b1}; end
      scr_pkg::STP_OBA: begin alu_x = ba_r;  alu_y = oa_r; end
      scr_pkg::STP_OBB: begin alu_x = bb_r;  alu_y = ob_r; end
      scr_pkg::STP_OEA: begin alu_x = final_r ? ea_r : oba_r; alu_y = final_r ? oa_r : lm1_r; end
      scr_pkg::STP_OEB: begin alu_x = final_r ? eb_r : obb_r; alu_y = final_r ? ob_r : lm1_r; end
      scr_pkg::STP_NBA: begin alu_x = ba_r;  alu_y = len_m; end
      scr_pkg::STP_NBB: begin alu_x = bb_r;  alu_y = len_m; end
      default: ;
    endcase
  end

  // ram addresses and writes
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    we_a    = 1'b0;
    we_b    = 1'b0;
    waddr   = cnt_s[AW-1:0];
    wdata   = '{pos: cp_r, off: rem_s};
    unique case (state_r)
      scr_pkg::S_F_RD1: begin raddr_a = cur_a_r + AW'(1); raddr_b = cur_b_r + AW'(1); end
      scr_pkg::S_F_RD0: begin raddr_a = cur_a_r;          raddr_b = cur_b_r;          end
      scr_pkg::S_UP_RD: begin raddr_a = idx_r + AW'(1);   raddr_b = idx_r + AW'(1);   end
      scr_pkg::S_DN_RD: begin raddr_a = idx_r;            raddr_b = idx_r;            end
      scr_pkg::S_CWR: begin
        we_a = !sel_r;
        we_b = sel_r;
      end
      scr_pkg::S_FIN_FLOOR: begin
        we_a  = !sel_r;
        we_b  = sel_r;
        waddr = '0;
        wdata = '0;
      end
      scr_pkg::S_FIN_CEIL: begin
        we_a  = !sel_r;
        we_b  = sel_r;
        wdata = '{pos: scr_pkg::CEILING_POS, off: scr_pkg::CEILING_POS};
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scr_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.func)
            scr_pkg::FUNC_LOAD_A, scr_pkg::FUNC_LOAD_B: state_nxt = scr_pkg::S_LOAD;
            scr_pkg::FUNC_FINISH:  state_nxt = scr_pkg::S_FIN;
            scr_pkg::FUNC_SEGMENT: state_nxt = scr_pkg::S_SEG;
            default: state_nxt = scr_pkg::S_IDLE;
          endcase
        end
      end
      scr_pkg::S_LOAD: begin
        if (!ready_r && !ld_bad && ld_new && !ld_full && pv_s) state_nxt = scr_pkg::S_ALU;
        else state_nxt = scr_pkg::S_EMIT;
      end
      scr_pkg::S_ALU: begin
        if (step_r == scr_pkg::STP_CR) state_nxt = scr_pkg::S_CWR;
        else if ((step_r == scr_pkg::STP_OEB && final_r) || step_r == scr_pkg::STP_NBB)
          state_nxt = scr_pkg::S_PIECE;
      end
      scr_pkg::S_CWR: begin
        state_nxt = (func_r == scr_pkg::FUNC_FINISH) ? scr_pkg::S_FIN_FLOOR : scr_pkg::S_EMIT;
      end
      scr_pkg::S_FIN:       state_nxt = ready_r ? scr_pkg::S_EMIT : scr_pkg::S_FIN_MAP;
      scr_pkg::S_FIN_MAP:   state_nxt = pv_s ? scr_pkg::S_ALU : scr_pkg::S_FIN_FLOOR;
      scr_pkg::S_FIN_FLOOR: state_nxt = scr_pkg::S_FIN_CEIL;
      scr_pkg::S_FIN_CEIL:  state_nxt = sel_r ? scr_pkg::S_FIN_DONE : scr_pkg::S_FIN_MAP;
      scr_pkg::S_FIN_DONE:  state_nxt = scr_pkg::S_EMIT;
      scr_pkg::S_SEG:       state_nxt = ready_r ? scr_pkg::S_F_RD1 : scr_pkg::S_EMIT;
      scr_pkg::S_F_RD1:     state_nxt = scr_pkg::S_F_NX;
      scr_pkg::S_F_NX: begin
        state_nxt = (init_r && init_fresh) ? scr_pkg::S_UP_RD : scr_pkg::S_F_RD0;
      end
      scr_pkg::S_F_RD0:     state_nxt = scr_pkg::S_F_CK;
      scr_pkg::S_F_CK:      state_nxt = seg_bad ? scr_pkg::S_EMIT : scr_pkg::S_ALU;
      scr_pkg::S_UP_RD:     state_nxt = scr_pkg::S_UP_CK;
      scr_pkg::S_DN_RD:     state_nxt = scr_pkg::S_DN_CK;
      scr_pkg::S_UP_CK, scr_pkg::S_DN_CK: begin
        if (srch_done) begin
          if (!sel_r) state_nxt = scr_pkg::S_UP_RD;
          else state_nxt = fail_now ? scr_pkg::S_EMIT : scr_pkg::S_F_RD1;
        end else if (state_r == scr_pkg::S_UP_CK) begin
          state_nxt = up_le ? scr_pkg::S_UP_RD : scr_pkg::S_DN_RD;
        end else begin
          state_nxt = scr_pkg::S_DN_RD;
        end
      end
      scr_pkg::S_PIECE:     state_nxt = scr_pkg::S_EMIT;
      scr_pkg::S_EMIT: begin
        if (out_free) state_nxt = em_r.last_piece ? scr_pkg::S_IDLE : scr_pkg::S_UP_RD;
      end
      default: state_nxt = scr_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    step_nxt = step_r;   func_nxt = func_r;   sel_nxt = sel_r;   first_nxt = first_r;
    ba_nxt = ba_r; bb_nxt = bb_r; ea_nxt = ea_r; eb_nxt = eb_r;
    len_a_nxt = len_a_r; len_b_nxt = len_b_r;
    cnt_a_nxt = cnt_a_r; cnt_b_nxt = cnt_b_r; pv_a_nxt = pv_a_r; pv_b_nxt = pv_b_r;
    pb_a_nxt = pb_a_r; pe_a_nxt = pe_a_r; pb_b_nxt = pb_b_r; pe_b_nxt = pe_b_r;
    rem_a_nxt = rem_a_r; rem_b_nxt = rem_b_r;
    cur_a_nxt = cur_a_r; cur_b_nxt = cur_b_r; idx_nxt = idx_r;
    ready_nxt = ready_r; group_nxt = group_r; bfirst_nxt = bfirst_r; blast_nxt = blast_r;
    fail_nxt = fail_r; init_nxt = init_r; fresh_nxt = fresh_r; final_nxt = final_r;
    n_nxt = n_r; na_nxt = na_r; nb_nxt = nb_r; oa_nxt = oa_r; ob_nxt = ob_r;
    da_nxt = da_r; db_nxt = db_r; lm1_nxt = lm1_r;
    oba_nxt = oba_r; obb_nxt = obb_r; oea_nxt = oea_r; oeb_nxt = oeb_r;
    cp_nxt = cp_r; ct_nxt = ct_r; em_nxt = em_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        scr_pkg::CFG_LEN_A: len_a_nxt = cfg_data;
        scr_pkg::CFG_LEN_B: len_b_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      // take one input beat
      scr_pkg::S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_data.func;
          first_nxt = in_data.first_of_alignment;
          ba_nxt = in_data.begin_a; bb_nxt = in_data.begin_b;
          ea_nxt = in_data.end_a;   eb_nxt = in_data.end_b;
          sel_nxt = (in_data.func == scr_pkg::FUNC_LOAD_B);
        end
      end
      // interval load decision
      scr_pkg::S_LOAD: begin
        em_nxt = scr_pkg::status_beat(scr_pkg::ST_OK);
        if (ready_r) begin
          em_nxt = scr_pkg::status_beat(scr_pkg::ST_OUT_OF_ORDER);
        end else if (ld_bad) begin
          em_nxt = scr_pkg::status_beat(scr_pkg::ST_BAD_INTERVAL);
        end else if (ld_new) begin
          if (ld_full) begin
            em_nxt = scr_pkg::status_beat(scr_pkg::ST_MAP_FULL);
          end else if (pv_s) begin
            step_nxt = scr_pkg::STP_CP;
          end else if (sel_r) begin
            pv_b_nxt = 1'b1; pb_b_nxt = ba_r; pe_b_nxt = ea_r;
          end else begin
            pv_a_nxt = 1'b1; pb_a_nxt = ba_r; pe_a_nxt = ea_r;
          end
        end else if (ba_r < pb_s) begin
          em_nxt = scr_pkg::status_beat(scr_pkg::ST_OUT_OF_ORDER);
        end else if (ea_r > pe_s) begin
          if (sel_r) pe_b_nxt = ea_r;
          else pe_a_nxt = ea_r;
        end
      end
      // one sum through the shared adder
      scr_pkg::S_ALU: begin
        unique case (step_r)
          scr_pkg::STP_CP:  begin cp_nxt = alu_r; step_nxt = scr_pkg::STP_CT; end
          scr_pkg::STP_CT:  begin ct_nxt = alu_r; step_nxt = scr_pkg::STP_CR; end
          scr_pkg::STP_CR: begin
            if (sel_r) rem_b_nxt = alu_r;
            else rem_a_nxt = alu_r;
          end
          scr_pkg::STP_DA:  begin da_nxt  = alu_r; step_nxt = scr_pkg::STP_DB;  end
          scr_pkg::STP_DB:  begin db_nxt  = alu_r; step_nxt = scr_pkg::STP_LM1; end
          scr_pkg::STP_LM1: begin lm1_nxt = alu_r; step_nxt = scr_pkg::STP_OBA; end
          scr_pkg::STP_OBA: begin oba_nxt = alu_r; step_nxt = scr_pkg::STP_OBB; end
          scr_pkg::STP_OBB: begin obb_nxt = alu_r; step_nxt = scr_pkg::STP_OEA; end
          scr_pkg::STP_OEA: begin oea_nxt = alu_r; step_nxt = scr_pkg::STP_OEB; end
          scr_pkg::STP_OEB: begin oeb_nxt = alu_r; step_nxt = scr_pkg::STP_NBA; end
          scr_pkg::STP_NBA: begin ba_nxt  = alu_r; step_nxt = scr_pkg::STP_NBB; end
          scr_pkg::STP_NBB: begin bb_nxt  = alu_r; end
          default: ;
        endcase
      end
      // commit the pending interval into its slot
      scr_pkg::S_CWR: begin
        if (sel_r) begin
          cnt_b_nxt = cnt_b_r + CW'(1);
          pv_b_nxt  = 1'b0;
          blast_nxt = cp_r;
          if (cnt_b_r == CW'(1)) bfirst_nxt = cp_r;
        end else begin
          cnt_a_nxt = cnt_a_r + CW'(1);
          pv_a_nxt  = 1'b0;
        end
        if (func_r != scr_pkg::FUNC_FINISH) begin
          em_nxt = scr_pkg::status_beat(scr_pkg::ST_OK);
          if (sel_r) begin
            pv_b_nxt = 1'b1; pb_b_nxt = ba_r; pe_b_nxt = ea_r;
          end else begin
            pv_a_nxt = 1'b1; pb_a_nxt = ba_r; pe_a_nxt = ea_r;
          end
        end
      end
      // finish maps
      scr_pkg::S_FIN: begin
        em_nxt  = scr_pkg::status_beat(scr_pkg::ST_OK);
        sel_nxt = 1'b0;
      end
      scr_pkg::S_FIN_MAP: begin
        step_nxt = scr_pkg::STP_CP;
      end
      scr_pkg::S_FIN_CEIL: begin
        if (sel_r) cnt_b_nxt = cnt_b_r + CW'(1);
        else cnt_a_nxt = cnt_a_r + CW'(1);
        sel_nxt = 1'b1;
      end
      scr_pkg::S_FIN_DONE: begin
        ready_nxt = 1'b1;
        cur_a_nxt = '0;
        cur_b_nxt = '0;
        group_nxt = 1'b0;
        em_nxt = scr_pkg::status_beat(fin_bad ? scr_pkg::ST_OUT_OF_ORDER : scr_pkg::ST_OK);
      end
      // segment start: clamp cursors
      scr_pkg::S_SEG: begin
        em_nxt = scr_pkg::status_beat(scr_pkg::ST_SEARCH_FAIL);
        if ({1'b0, cur_a_r} > lim_a) cur_a_nxt = lim_a[AW-1:0];
        if ({1'b0, cur_b_r} > lim_b) cur_b_nxt = lim_b[AW-1:0];
        n_nxt    = '0;
        init_nxt = 1'b1;
      end
      // upper bounds of the current entries
      scr_pkg::S_F_NX: begin
        na_nxt = rd_a.pos;
        nb_nxt = rd_b.pos;
        if (init_r) begin
          init_nxt  = 1'b0;
          fresh_nxt = init_fresh;
          if (init_fresh) begin
            sel_nxt = 1'b0; idx_nxt = cur_a_r; fail_nxt = 1'b0;
          end
        end
      end
      // entry check and piece setup
      scr_pkg::S_F_CK: begin
        oa_nxt = rd_a.off;
        ob_nxt = rd_b.off;
        if (seg_bad) begin
          group_nxt = 1'b0;
          em_nxt = scr_pkg::status_beat(scr_pkg::ST_BAD_SEGMENT);
        end else begin
          final_nxt = seg_fin;
          step_nxt  = seg_fin ? scr_pkg::STP_OBA : scr_pkg::STP_DA;
        end
      end
      // linear search, one entry per step
      scr_pkg::S_UP_CK, scr_pkg::S_DN_CK: begin
        if (srch_done) begin
          if (srch_fail) begin
            fail_nxt = 1'b1;
            if (sel_r) cur_b_nxt = '0;
            else cur_a_nxt = '0;
          end else if (sel_r) begin
            cur_b_nxt = idx_r;
          end else begin
            cur_a_nxt = idx_r;
          end
          if (!sel_r) begin
            sel_nxt = 1'b1;
            idx_nxt = cur_b_r;
          end else if (fail_now) begin
            group_nxt = 1'b0;
            em_nxt = scr_pkg::status_beat(scr_pkg::ST_SEARCH_FAIL);
          end
        end else if (state_r == scr_pkg::S_UP_CK) begin
          if (up_le) idx_nxt = nidx[AW-1:0];
        end else begin
          idx_nxt = idx_r - AW'(1);
        end
      end
      // build the piece beat
      scr_pkg::S_PIECE: begin
        em_nxt.orig_begin_a = oba_r;
        em_nxt.orig_begin_b = obb_r;
        em_nxt.orig_end_a   = oea_r;
        em_nxt.orig_end_b   = oeb_r;
        em_nxt.group_start  = fresh_r;
        em_nxt.status       = scr_pkg::ST_OK;
        em_nxt.last_piece   = 1'b1;
        if (final_r) begin
          group_nxt = 1'b1;
        end else begin
          group_nxt = 1'b0;
          n_nxt     = n_r + NW'(1);
          if (piece_over) begin
            em_nxt.status = scr_pkg::ST_BAD_SEGMENT;
          end else if (piece_max) begin
            em_nxt.status = scr_pkg::ST_TOO_MANY;
          end else begin
            em_nxt.last_piece = 1'b0;
            fresh_nxt = 1'b1;
          end
        end
      end
      // hand the beat to the output register
      scr_pkg::S_EMIT: begin
        if (out_free) begin
          out_data_nxt  = em_r;
          out_valid_nxt = 1'b1;
          if (!em_r.last_piece) begin
            sel_nxt = 1'b0; idx_nxt = cur_a_r; fail_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scr_pkg::S_IDLE;
      len_a_r     <= scr_pkg::LEN_RESET;
      len_b_r     <= scr_pkg::LEN_RESET;
      cnt_a_r     <= CW'(1);
      cnt_b_r     <= CW'(1);
      pv_a_r      <= 1'b0;
      pv_b_r      <= 1'b0;
      rem_a_r     <= '0;
      rem_b_r     <= '0;
      cur_a_r     <= '0;
      cur_b_r     <= '0;
      ready_r     <= 1'b0;
      group_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      pv_a_r      <= pv_a_nxt;
      pv_b_r      <= pv_b_nxt;
      rem_a_r     <= rem_a_nxt;
      rem_b_r     <= rem_b_nxt;
      cur_a_r     <= cur_a_nxt;
      cur_b_r     <= cur_b_nxt;
      ready_r     <= ready_nxt;
      group_r     <= group_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    step_r <= step_nxt;   func_r <= func_nxt;   sel_r <= sel_nxt;   first_r <= first_nxt;
    ba_r <= ba_nxt; bb_r <= bb_nxt; ea_r <= ea_nxt; eb_r <= eb_nxt;
    pb_a_r <= pb_a_nxt; pe_a_r <= pe_a_nxt; pb_b_r <= pb_b_nxt; pe_b_r <= pe_b_nxt;
    idx_r <= idx_nxt; bfirst_r <= bfirst_nxt; blast_r <= blast_nxt;
    fail_r <= fail_nxt; init_r <= init_nxt; fresh_r <= fresh_nxt; final_r <= final_nxt;
    n_r <= n_nxt; na_r <= na_nxt; nb_r <= nb_nxt; oa_r <= oa_nxt; ob_r <= ob_nxt;
    da_r <= da_nxt; db_r <= db_nxt; lm1_r <= lm1_nxt;
    oba_r <= oba_nxt; obb_r <= obb_nxt; oea_r <= oea_nxt; oeb_r <= oeb_nxt;
    cp_r <= cp_nxt; ct_r <= ct_nxt; em_r <= em_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != scr_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/scr_checker.sv]
// scr_checker: port-level assertions for the segment coordinate restorer
// depends on scr_pkg; bound to segment_coordinate_restorer below

module scr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input scr_pkg::out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // an accepted item keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took items in back-to-back cycles");

  // search failures carry no coordinates and end the item
  a_search_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == scr_pkg::ST_SEARCH_FAIL |->
      out_data.last_piece && !out_data.group_start &&
      out_data.orig_begin_a == '0 && out_data.orig_end_b == '0)
    else $error("search failure beat malformed");

  // bad intervals, full maps and piece overflow always end the item
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == scr_pkg::ST_TOO_MANY ||
                  out_data.status == scr_pkg::ST_BAD_INTERVAL ||
                  out_data.status == scr_pkg::ST_MAP_FULL) |-> out_data.last_piece)
    else $error("terminal status without last piece");

endmodule

bind segment_coordinate_restorer scr_checker u_scr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
